[sv/i2r_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, constants and digit-shape helpers for the Roman numeral
// converter.
// ----------------------------------------------------------------------------
package i2r_pkg;

    localparam int VAL_W       = 12;
    localparam int SYM_W       = 8;
    localparam int DIG_W       = 4;
    localparam int PLACES      = 4;
    localparam int PLC_W       = $clog2(PLACES);
    localparam int K_W         = 2;
    localparam int LEN_W       = K_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VAL_W-1:0] MAX_VALUE = 12'd3999;
    localparam logic [SYM_W-1:0] ERR_SYMBOL = 8'd0;

    typedef logic [DIG_W-1:0] t_digit;
    typedef logic [PLC_W-1:0] t_place;
    typedef logic [K_W-1:0]   t_k;
    typedef logic [LEN_W-1:0] t_len;
    typedef logic [1:0]       t_slot;

    localparam t_slot SLOT_ONE  = 2'd0;
    localparam t_slot SLOT_FIVE = 2'd1;
    localparam t_slot SLOT_TEN  = 2'd2;

    typedef struct packed {
        logic                    err;
        t_digit [PLACES-1:0]     dig;
    } t_item;

    typedef struct packed {
        logic   found;
        t_place place;
    } t_next;

    // letters per place: units, tens, hundreds, thousands
    localparam logic [SYM_W-1:0] LETTERS [PLACES][3] = '{
        '{"I", "V", "X"},
        '{"X", "L", "C"},
        '{"C", "D", "M"},
        '{"M", "M", "M"}
    };

    function automatic t_len shape_len(input t_digit d);
        t_len len;
        case (d)
            4'd1:    len = 3'd1;
            4'd2:    len = 3'd2;
            4'd3:    len = 3'd3;
            4'd4:    len = 3'd2;
            4'd5:    len = 3'd1;
            4'd6:    len = 3'd2;
            4'd7:    len = 3'd3;
            4'd8:    len = 3'd4;
            4'd9:    len = 3'd2;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic t_slot shape_slot(input t_digit d, input t_k k);
        t_slot s;
        case (d)
            4'd4:             s = (k == '0) ? SLOT_ONE  : SLOT_FIVE;
            4'd5:             s = SLOT_FIVE;
            4'd6, 4'd7, 4'd8: s = (k == '0) ? SLOT_FIVE : SLOT_ONE;
            4'd9:             s = (k == '0) ? SLOT_ONE  : SLOT_TEN;
            default:          s = SLOT_ONE;
        endcase
        return s;
    endfunction

    function automatic logic [SYM_W-1:0] letter(input t_place p, input t_slot s);
        logic [SYM_W-1:0] c;
        case (s)
            SLOT_ONE:  c = LETTERS[p][0];
            SLOT_FIVE: c = LETTERS[p][1];
            SLOT_TEN:  c = LETTERS[p][2];
            default:   c = LETTERS[p][0];
        endcase
        return c;
    endfunction

    function automatic t_place top_place(input t_digit [PLACES-1:0] dig);
        t_place p;
        p = '0;
        for (int i = 0; i < PLACES; i++) begin
            if (dig[i] != '0) p = PLC_W'(i);
        end
        return p;
    endfunction

    // highest non-zero place below p
    function automatic t_next next_place(input t_digit [PLACES-1:0] dig, input t_place p);
        t_next n;
        n = '0;
        for (int i = 0; i < PLACES; i++) begin
            if ((PLC_W'(i) < p) && (dig[i] != '0)) begin
                n.found = 1'b1;
                n.place = PLC_W'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

[sv/i2r_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_front
// Takes values, flags range errors and zeros, splits valid values into
// decimal digits and pushes work items to the queue.
// ----------------------------------------------------------------------------
module i2r_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    input  wire  [i2r_pkg::VAL_W-1:0]    i_value,
    output logic                         o_full,
    output logic                         o_q_push,
    output i2r_pkg::t_item               o_q_item,
    input  wire                          i_q_full
);
    import i2r_pkg::*;

    // reciprocal multipliers, exact for values up to 3999
    localparam logic [15:0] RECIP_10   = 16'd52429;
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam logic [13:0] RECIP_1000 = 14'd8389;

    logic             r_vld;
    logic             r_err;
    logic             r_zero;
    logic [VAL_W-1:0] r_v;
    logic [8:0]       r_q1;
    logic [5:0]       r_q2;
    logic [2:0]       r_q3;

    logic [27:0] p1;
    logic [24:0] p2;
    logic [25:0] p3;
    logic        acc;
    logic        adv;
    logic [11:0] t0;
    logic [8:0]  t1;
    logic [5:0]  t2;

    assign p1 = 28'(i_value) * 28'(RECIP_10);
    assign p2 = 25'(i_value) * 25'(RECIP_100);
    assign p3 = 26'(i_value) * 26'(RECIP_1000);

    assign o_full   = r_vld && !r_zero && i_q_full;
    assign acc      = i_push && !o_full;
    assign adv      = r_vld && (r_zero || !i_q_full);
    assign o_q_push = r_vld && !r_zero && !i_q_full;

    assign t0 = r_v - 12'({3'b0, r_q1} * 12'd10);
    assign t1 = r_q1 - 9'({3'b0, r_q2} * 9'd10);
    assign t2 = r_q2 - 6'({3'b0, r_q3} * 6'd10);

    always_comb begin
        o_q_item.err    = r_err;
        o_q_item.dig[0] = t0[DIG_W-1:0];
        o_q_item.dig[1] = t1[DIG_W-1:0];
        o_q_item.dig[2] = t2[DIG_W-1:0];
        o_q_item.dig[3] = {1'b0, r_q3};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (acc) begin
            r_vld <= 1'b1;
        end else if (adv) begin
            r_vld <= 1'b0;
        end
        if (acc) begin
            r_v    <= i_value;
            r_err  <= i_value > MAX_VALUE;
            r_zero <= i_value == '0;
            r_q1   <= p1[27:19];
            r_q2   <= p2[24:19];
            r_q3   <= p3[25:23];
        end
    end

endmodule
`default_nettype wire

[sv/i2r_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_queue
// Short register queue of digit items between front and back.
// ----------------------------------------------------------------------------
module i2r_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  i2r_pkg::t_item  i_item,
    output logic            o_full,
    output logic            o_vld,
    output i2r_pkg::t_item  o_item,
    input  wire             i_pop
);
    import i2r_pkg::*;

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == QCNT_W'(QUEUE_DEPTH);
    assign o_vld   = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (do_pop)  r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            if (do_push && !do_pop)      r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
        if (do_push) r_mem[r_wp] <= i_item;
    end

endmodule
`default_nettype wire

[sv/i2r_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// i2r_back
// Walks the digits of one item and writes one letter per beat into the
// output register, thousands first; an error item gives one zero beat.
// ----------------------------------------------------------------------------
module i2r_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_vld,
    input  i2r_pkg::t_item               i_q_item,
    output logic                         o_q_pop,
    output logic                         o_empty,
    input  wire                          i_pop,
    output logic [i2r_pkg::SYM_W-1:0]    o_symbol,
    output logic                         o_last,
    output logic                         o_error
);
    import i2r_pkg::*;

    logic             r_act;
    t_item            r_item;
    t_place           r_place;
    t_k               r_k;
    logic             r_ov;
    logic [SYM_W-1:0] r_sym;
    logic             r_last;
    logic             r_err;

    t_item            cur_item;
    t_place           cur_place;
    t_k               cur_k;
    logic             cur_vld;
    logic             out_rdy;
    logic             fire;
    t_digit           cur_dig;
    t_len             k_inc;
    logic             more_k;
    t_next            nxt;
    logic             done;
    logic [SYM_W-1:0] sym;

    always_comb begin
        if (r_act) begin
            cur_item  = r_item;
            cur_place = r_place;
            cur_k     = r_k;
        end else begin
            cur_item  = i_q_item;
            cur_place = top_place(i_q_item.dig);
            cur_k     = '0;
        end
        cur_vld = r_act || i_q_vld;
        out_rdy = !r_ov || i_pop;
        fire    = cur_vld && out_rdy;
        cur_dig = cur_item.dig[cur_place];
        k_inc   = {1'b0, cur_k} + 3'd1;
        more_k  = k_inc < shape_len(cur_dig);
        nxt     = next_place(cur_item.dig, cur_place);
        done    = cur_item.err || (!more_k && !nxt.found);
        sym     = cur_item.err ? ERR_SYMBOL
                               : letter(cur_place, shape_slot(cur_dig, cur_k));
    end

    assign o_q_pop  = fire && !r_act;
    assign o_empty  = !r_ov;
    assign o_symbol = r_sym;
    assign o_last   = r_last;
    assign o_error  = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (fire) begin
                r_act <= !done;
                r_ov  <= 1'b1;
            end else if (i_pop) begin
                r_ov  <= 1'b0;
            end
        end
        if (fire) begin
            r_item  <= cur_item;
            r_k     <= more_k ? k_inc[K_W-1:0] : '0;
            r_place <= more_k ? cur_place : nxt.place;
            r_sym   <= sym;
            r_last  <= done;
            r_err   <= cur_item.err;
        end
    end

endmodule
`default_nettype wire

[sv/integer_to_roman_numeral.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts a 12-bit unsigned value into its Roman numeral, one ASCII letter
// per output beat, with last on the final letter.
// ----------------------------------------------------------------------------
// A value of 1 to 3999 yields one beat per letter of its numeral (1 to 15
// beats, 3888 being the longest); 0 yields no beat; 4000 to 4095 yield one
// beat with symbol 0, last and error set. The letter sequencer in the back
// end produces one letter per cycle while its output register is free or
// popped. The front end takes one value per cycle while not full into a
// two-entry item queue and drops zeros there; a value's first letter
// passes the front register, the item queue and the output register.
// ----------------------------------------------------------------------------
module integer_to_roman_numeral (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_push,
    output logic                         o_full,
    input  wire  [i2r_pkg::VAL_W-1:0]    i_value,
    output logic                         o_empty,
    input  wire                          i_pop,
    output logic [i2r_pkg::SYM_W-1:0]    o_symbol,
    output logic                         o_last,
    output logic                         o_error
);
    import i2r_pkg::*;

    logic  f_push;
    t_item f_item;
    logic  q_full;
    logic  q_vld;
    t_item q_item;
    logic  q_pop;

    i2r_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_value  (i_value),
        .o_full   (o_full),
        .o_q_push (f_push),
        .o_q_item (f_item),
        .i_q_full (q_full)
    );

    i2r_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_item  (f_item),
        .o_full  (q_full),
        .o_vld   (q_vld),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    i2r_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (q_vld),
        .i_q_item (q_item),
        .o_q_pop  (q_pop),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_error  (o_error)
    );

    a_err_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_error) |-> (o_last && o_symbol == ERR_SYMBOL))
        else $error("error beat must be a single zero symbol");

    a_letter : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_error) |-> (o_symbol == "I" || o_symbol == "V" ||
            o_symbol == "X" || o_symbol == "L" || o_symbol == "C" ||
            o_symbol == "D" || o_symbol == "M"))
        else $error("non-error beat carries a non-Roman symbol");

    a_queue_push : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !q_full)
        else $error("front pushed into a full queue");

    a_pop_src : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_vld)
        else $error("back popped an empty queue");

endmodule
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Bench for the Roman numeral converter. Values are pushed through the input
// queue port, and every output beat is checked against letters spelled out
// locally from the value's decimal digits. The run starts with directed
// values (extremes, every digit form, out-of-range values), then random
// traffic with and without idle gaps on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    import i2r_pkg::*;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             error;
    } t_roman_beat;

    localparam logic [SYM_W-1:0] GLYPHS [4][3] = '{
        '{"I", "V", "X"},
        '{"X", "L", "C"},
        '{"C", "D", "M"},
        '{"M", "M", "M"}
    };

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_push  = 1'b0;
    logic [VAL_W-1:0] i_value = '0;
    logic             i_pop   = 1'b0;
    logic             o_full;
    logic             o_empty;
    logic [SYM_W-1:0] o_symbol;
    logic             o_last;
    logic             o_error;

    t_roman_beat numeral_beats[$];
    int          errors       = 0;
    int          values_sent  = 0;
    int          beats_seen   = 0;
    bit          push_gaps    = 1'b0;
    bit          pop_stalls   = 1'b0;
    int          stall_left   = 0;

    integer_to_roman_numeral dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .o_full   (o_full),
        .i_value  (i_value),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_symbol (o_symbol),
        .o_last   (o_last),
        .o_error  (o_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    // expected beats for one value, appended to the numeral queue
    function automatic void spell_numeral(input logic [VAL_W-1:0] v);
        t_roman_beat run[$];
        t_roman_beat b;
        int          dig [4];
        int          rest;
        if (v > MAX_VALUE) begin
            b.symbol = ERR_SYMBOL;
            b.last   = 1'b1;
            b.error  = 1'b1;
            numeral_beats.push_back(b);
            return;
        end
        rest = int'(v);
        for (int p = 0; p < 4; p++) begin
            dig[p] = rest % 10;
            rest   = rest / 10;
        end
        b.last  = 1'b0;
        b.error = 1'b0;
        for (int p = 3; p >= 0; p--) begin
            case (dig[p])
                1, 2, 3: begin
                    for (int k = 0; k < dig[p]; k++) begin
                        b.symbol = GLYPHS[p][0];
                        run.push_back(b);
                    end
                end
                4: begin
                    b.symbol = GLYPHS[p][0];
                    run.push_back(b);
                    b.symbol = GLYPHS[p][1];
                    run.push_back(b);
                end
                5, 6, 7, 8: begin
                    b.symbol = GLYPHS[p][1];
                    run.push_back(b);
                    for (int k = 5; k < dig[p]; k++) begin
                        b.symbol = GLYPHS[p][0];
                        run.push_back(b);
                    end
                end
                9: begin
                    b.symbol = GLYPHS[p][0];
                    run.push_back(b);
                    b.symbol = GLYPHS[p][2];
                    run.push_back(b);
                end
                default: ;
            endcase
        end
        if (run.size() > 0) run[run.size()-1].last = 1'b1;
        foreach (run[i]) numeral_beats.push_back(run[i]);
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("ERROR: %s", msg);
    endtask

    // entered just after a rising edge; leaves i_push high after the beat
    task automatic send_value(input logic [VAL_W-1:0] v);
        int gap;
        gap = push_gaps ? pick_idle() : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_push <= 1'b0;
        end
        @(negedge i_clk);
        i_push  <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_full);
        spell_numeral(v);
        values_sent++;
    endtask

    // output side: random stalls on pop
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_pop      <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_pop <= 1'b1;
            if (pop_stalls) stall_left <= pick_idle();
        end
    end

    always @(posedge i_clk) begin
        t_roman_beat want;
        if (i_rst_n && i_pop && !o_empty) begin
            beats_seen++;
            if (numeral_beats.size() == 0) begin
                flag_error($sformatf("unexpected beat symbol=%0h last=%0b error=%0b",
                                     o_symbol, o_last, o_error));
            end else begin
                want = numeral_beats.pop_front();
                if (o_symbol !== want.symbol || o_last !== want.last ||
                    o_error !== want.error) begin
                    flag_error($sformatf(
                        "beat mismatch: exp symbol=%0h last=%0b error=%0b, got %0h %0b %0b",
                        want.symbol, want.last, want.error, o_symbol, o_last, o_error));
                end
            end
        end
    end

    task automatic test_extremes();
        send_value(12'd0);
        send_value(12'd1);
        send_value(12'd3999);
        send_value(12'd4000);
        send_value(12'd4095);
        send_value(12'd3888);
        send_value(12'd0);
        send_value(12'd1001);
        send_value(12'd3090);
    endtask

    task automatic test_digit_forms();
        for (int d = 1; d <= 9; d++) send_value(VAL_W'(d * 111));
        for (int d = 1; d <= 3; d++) send_value(VAL_W'(d * 1000));
    endtask

    task automatic test_random_values(input int count);
        int               r;
        logic [VAL_W-1:0] v;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 5)       v = '0;
            else if (r < 11) v = VAL_W'($urandom_range(4000, 4095));
            else if (r < 25) v = VAL_W'($urandom_range(1, 99));
            else if (r < 30) v = 12'd3888;
            else             v = VAL_W'($urandom_range(1, 3999));
            send_value(v);
        end
    endtask

    task automatic test_back_to_back();
        push_gaps  = 1'b0;
        pop_stalls = 1'b0;
        test_random_values(80);
    endtask

    task automatic test_idle_traffic();
        push_gaps  = 1'b1;
        pop_stalls = 1'b1;
        test_random_values(160);
        push_gaps  = 1'b0;
        test_random_values(40);
        push_gaps  = 1'b1;
        pop_stalls = 1'b0;
        test_random_values(40);
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_digit_forms();
        test_back_to_back();
        test_idle_traffic();
        @(negedge i_clk);
        i_push <= 1'b0;
        while (numeral_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Converted %0d values, checked %0d letter beats, %0d mismatches.",
                 values_sent, beats_seen, errors);
        $display("Covered zero, out-of-range, every digit form and idle/stall mixes.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

[integer_to_roman_numeral.f]
sv/i2r_pkg.sv
sv/i2r_front.sv
sv/i2r_queue.sv
sv/i2r_back.sv
sv/integer_to_roman_numeral.sv
bench/tb_top.sv
